>>> design/tle_pkg.sv
// Shared types and character codes for the terminal line edit buffer.
// No dependencies; used by tle_line_ctrl and tty_line_edit_buffer_unit.
package tle_pkg;

  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_EOF       = 8'd255;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // One result item as it leaves the block.
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       line_ready;
    logic       dropped;
    logic       read_valid;
    logic [7:0] read_char;
    logic       store_empty;
  } result_t;

endpackage

>>> design/tty_line_edit_buffer_unit.sv
// Terminal line edit buffer, top level: echo configuration register and
// port mapping. Depends on tle_pkg, tle_line_ctrl and tle_ring_mem.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: a key
//   character (operation_i = 0) or a read of the oldest stored character
//   (operation_i = 1). Output channel (out_valid_o / out_stall_i) carries
//   at most one result per item; a backspace that erases nothing gives none.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the echo
//   enable bit; it is always ready and should be written while idle.
// Timing:
//   An accepted item waits in the input register; its result is then
//   registered in the result register. One item per cycle is sustained
//   unless the receiver stalls; the ring memory is prefetched with
//   registered reads of the oldest and newest characters every cycle.
// Reset clears the ring pointers and fill count (the ring is empty) and
// sets echo on. When the receiver stalls, the result register holds its
// transfer and the input stall rises once the input register is also full.
module tty_line_edit_buffer_unit #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       echo_valid_o,
  output logic [7:0] echo_char_o,
  output logic       line_ready_o,
  output logic       dropped_o,
  output logic       read_valid_o,
  output logic [7:0] read_char_o,
  output logic       store_empty_o
);

  logic             echo_en_q;
  tle_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      echo_en_q <= cfg_data_i;
    end
  end

  tle_line_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .echo_en_i   (echo_en_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .char_code_i (char_code_i),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign echo_valid_o  = res.echo_valid;
  assign echo_char_o   = res.echo_char;
  assign line_ready_o  = res.line_ready;
  assign dropped_o     = res.dropped;
  assign read_valid_o  = res.read_valid;
  assign read_char_o   = res.read_char;
  assign store_empty_o = res.store_empty;

endmodule

>>> design/tle_ring_mem.sv
// Character ring memory: one write port and two registered read ports.
// A read of the address written at the same edge returns the new data.
// No package dependencies.
module tle_ring_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd0_addr_i,
  input  logic [AW-1:0] rd1_addr_i,
  output logic [7:0]    rd0_data_o,
  output logic [7:0]    rd1_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd0_q, rd1_q, wdata_q;
  logic       byp0_q, byp1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd0_q   <= mem[rd0_addr_i];
    rd1_q   <= mem[rd1_addr_i];
    wdata_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp0_q <= 1'b0;
      byp1_q <= 1'b0;
    end else begin
      byp0_q <= wr_en_i && (wr_addr_i == rd0_addr_i);
      byp1_q <= wr_en_i && (wr_addr_i == rd1_addr_i);
    end
  end

  assign rd0_data_o = byp0_q ? wdata_q : rd0_q;
  assign rd1_data_o = byp1_q ? wdata_q : rd1_q;

endmodule

>>> design/tle_line_ctrl.sv
// Line discipline control: input register, ring pointers, key and read
// decoding, and the result register. Depends on tle_pkg and tle_ring_mem.
module tle_line_ctrl #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            echo_en_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [7:0]      char_code_i,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output tle_pkg::result_t res_o
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUF_DEPTH);

  logic            in_valid_q, op_q;
  logic [7:0]      ch_q;
  logic [AW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            res_valid_q, res_valid_d;
  tle_pkg::result_t res_q, step_res;
  logic            res_free, fire, has_res, wr_en;
  logic [AW-1:0]   last_addr, tail_prev;
  logic [7:0]      head_char, last_char;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - AW'(1);
  endfunction

  // The input register holds an item until the result register has room.
  assign res_free   = !res_valid_q || !res_stall_i;
  assign fire       = in_valid_q && res_free;
  assign in_stall_o = in_valid_q && !res_free;
  assign tail_prev  = ring_prev(tail_q);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    wr_en    = 1'b0;
    has_res  = 1'b0;
    step_res = '0;
    if (fire) begin
      if (op_q == tle_pkg::OP_READ) begin
        has_res = 1'b1;
        if (fill_q != '0) begin
          step_res.read_valid = 1'b1;
          step_res.read_char  = head_char;
          head_d              = ring_next(head_q);
          fill_d              = fill_q - CW'(1);
        end
      end else if (ch_q == tle_pkg::KEY_BACKSPACE) begin
        // A backspace never erases past an empty ring or a newline.
        if (fill_q != '0 && last_char != tle_pkg::KEY_NEWLINE) begin
          has_res              = 1'b1;
          tail_d               = tail_prev;
          fill_d               = fill_q - CW'(1);
          step_res.echo_valid  = echo_en_i;
          step_res.echo_char   = echo_en_i ? ch_q : 8'd0;
        end
      end else if (fill_q == FULL_CNT) begin
        has_res          = 1'b1;
        step_res.dropped = 1'b1;
      end else begin
        has_res             = 1'b1;
        wr_en               = 1'b1;
        tail_d              = ring_next(tail_q);
        fill_d              = fill_q + CW'(1);
        step_res.line_ready = (ch_q == tle_pkg::KEY_NEWLINE) ||
                              (ch_q == tle_pkg::KEY_EOF);
        step_res.echo_valid = echo_en_i;
        step_res.echo_char  = echo_en_i ? ch_q : 8'd0;
      end
    end
    step_res.store_empty = (fill_d == '0);
    res_valid_d = (fire && has_res) ? 1'b1 : (res_valid_q && res_stall_i);
  end

  // Prefetch the oldest and newest characters of the next state.
  assign last_addr = ring_prev(tail_d);

  tle_ring_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (tail_q),
    .wr_data_i  (ch_q),
    .rd0_addr_i (head_d),
    .rd1_addr_i (last_addr),
    .rd0_data_o (head_char),
    .rd1_data_o (last_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q <= operation_i;
      ch_q <= char_code_i;
    end
    if (fire && has_res) begin
      res_q <= step_res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
